// File: hdl/delimiter_motion_scanner_unit_defines.svh
//------------------------------------------------------------------------------
// Delimiter motion scanner assertion macros
// Clocked, reset-qualified assertion shorthands for the scanner RTL.
//------------------------------------------------------------------------------
`ifndef DELIMITER_MOTION_SCANNER_UNIT_DEFINES_SVH
`define DELIMITER_MOTION_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication on i_clk, off while i_rst_n is low
`define DMS_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication on i_clk, off while i_rst_n is low
`define DMS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hdl/dms_pkg.sv
//------------------------------------------------------------------------------
// Delimiter motion scanner package
// Shared sizes, register indexes, end modes and balance limits.
//------------------------------------------------------------------------------
package dms_pkg;

    localparam int MAX_SET_CHARS = 8;
    localparam int BALANCE_BITS  = 16;

    localparam int CHAR_W  = 8;
    localparam int SET_W   = CHAR_W * MAX_SET_CHARS;
    localparam int CNT_W   = 4;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SET_CHARS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_CHARS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANTI_CHARS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANTI_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PARA_BREAKS = 3'd5;

    // end modes
    localparam logic [1:0] END_BEFORE = 2'd0;
    localparam logic [1:0] END_ON     = 2'd1;
    localparam logic [1:0] END_AFTER  = 2'd2;

    // request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef logic signed [BALANCE_BITS-1:0] t_balance;

    localparam t_balance BAL_MAX  = $signed({1'b0, {(BALANCE_BITS-1){1'b1}}});
    localparam t_balance BAL_MIN  = ~BAL_MAX;
    localparam t_balance BAL_ZERO = '0;
    localparam t_balance BAL_ONE  = BALANCE_BITS'(1);

    typedef struct packed {
        logic       row_changed;
        logic       char_present;
        logic [7:0] character;
    } t_in_word;

endpackage

// File: hdl/dms_set_match.sv
//------------------------------------------------------------------------------
// Delimiter motion scanner set match
// Compares one character against a packed set of up to MAX_SET_CHARS bytes.
//------------------------------------------------------------------------------
module dms_set_match (
    input  logic [dms_pkg::SET_W-1:0]  i_chars,
    input  logic [dms_pkg::CNT_W-1:0]  i_count,
    input  logic [dms_pkg::CHAR_W-1:0] i_char,
    output logic                       o_hit,
    output logic                       o_nonempty
);

    logic [dms_pkg::CNT_W-1:0] eff_count;

    // clamp an oversized count to the set size
    assign eff_count  = (i_count > dms_pkg::MAX_CNT) ? dms_pkg::MAX_CNT : i_count;
    assign o_nonempty = (eff_count != '0);

    always_comb begin
        o_hit = 1'b0;
        for (int i = 0; i < dms_pkg::MAX_SET_CHARS; i++) begin
            if ((i < int'(eff_count)) &&
                (i_chars[dms_pkg::CHAR_W*i +: dms_pkg::CHAR_W] == i_char)) begin
                o_hit = 1'b1;
            end
        end
    end

endmodule

// File: hdl/delimiter_motion_scanner_unit.sv
//------------------------------------------------------------------------------
// Delimiter motion scanner unit
// Decides where a cursor motion stops as text characters stream in.
//------------------------------------------------------------------------------
// One input word per clock, one result word per input word. Each word is
// judged in the cycle it is accepted: two set compares and a saturating
// balance update feed the scan state and the output register directly, so
// the result is registered on acceptance, and a new word is taken in
// every cycle while the output register is empty or being drained. A start
// word (tuser = 0) opens a scan; step words (tuser = 1) report stop and
// back_one. After a stop, step words report nothing until the next start.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data, only while
// the stream is idle (a user rule the block does not enforce); indexes 0..5 select
// delimiter chars, delimiter count, anti chars, anti count, end mode and paragraph breaks.
`include "delimiter_motion_scanner_unit_defines.svh"

module delimiter_motion_scanner_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [dms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dms_pkg::CFG_W-1:0]       i_cfg_data,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [15:0]                     i_s_axis_tdata,  // character, char_present, row_changed, pad
    input  logic [0:0]                      i_s_axis_tuser,  // req_type
    // result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [7:0]                      o_m_axis_tdata   // stop, back_one, pad
);

    // configuration registers
    logic [dms_pkg::SET_W-1:0] r_delim_chars;
    logic [dms_pkg::CNT_W-1:0] r_delim_count;
    logic [dms_pkg::SET_W-1:0] r_anti_chars;
    logic [dms_pkg::CNT_W-1:0] r_anti_count;
    logic [1:0]                r_end_mode;
    logic                      r_para_breaks;

    // scan state
    logic              r_seen_delim,  n_seen_delim;
    logic              r_seen_other,  n_seen_other;
    dms_pkg::t_balance r_balance,     n_balance;
    logic              r_done,        n_done;

    // output register
    logic r_out_valid;
    logic r_out_stop, n_stop;
    logic r_out_back, n_back;

    dms_pkg::t_in_word in_word;
    logic              accept;
    logic              is_start;
    logic              delim_hit;
    logic              anti_hit;
    logic              nesting;
    logic              unused_nonempty;
    logic              row_delim;
    logic              sd;
    dms_pkg::t_balance bal_inc;
    dms_pkg::t_balance bal_dec;

    assign in_word  = dms_pkg::t_in_word'(i_s_axis_tdata[9:0]);
    assign is_start = (i_s_axis_tuser[0] == dms_pkg::REQ_START);

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_back, r_out_stop};

    dms_set_match u_delim_match (
        .i_chars    (r_delim_chars),
        .i_count    (r_delim_count),
        .i_char     (in_word.character),
        .o_hit      (delim_hit),
        .o_nonempty (unused_nonempty)
    );

    dms_set_match u_anti_match (
        .i_chars    (r_anti_chars),
        .i_count    (r_anti_count),
        .i_char     (in_word.character),
        .o_hit      (anti_hit),
        .o_nonempty (nesting)
    );

    assign bal_inc = (r_balance == dms_pkg::BAL_MAX) ? r_balance : r_balance + dms_pkg::BAL_ONE;
    assign bal_dec = (r_balance == dms_pkg::BAL_MIN) ? r_balance : r_balance - dms_pkg::BAL_ONE;

    // a row change counts as a delimiter when paragraph breaks are on
    assign row_delim = r_para_breaks && in_word.row_changed;

    always_comb begin
        n_seen_delim = r_seen_delim;
        n_seen_other = r_seen_other;
        n_balance    = r_balance;
        n_done       = r_done;
        n_stop       = 1'b0;
        n_back       = 1'b0;
        sd           = r_seen_delim;

        if (is_start) begin
            n_seen_delim = 1'b0;
            n_balance    = dms_pkg::BAL_ZERO;
            n_seen_other = !in_word.char_present || !delim_hit;
            n_done       = 1'b0;
        end else if (!r_done) begin
            if (row_delim && (r_end_mode == dms_pkg::END_BEFORE)) begin
                n_stop = 1'b1;
                n_back = 1'b1;
            end else begin
                if (row_delim) begin
                    sd = 1'b1;
                end
                n_seen_delim = sd;
                if (in_word.char_present) begin
                    if (delim_hit) begin
                        n_seen_delim = 1'b1;
                        if (r_balance != dms_pkg::BAL_ZERO) begin
                            n_balance = bal_dec;
                        end else if ((r_end_mode == dms_pkg::END_BEFORE) && r_seen_other) begin
                            n_stop = 1'b1;
                            n_back = 1'b1;
                        end else if (r_end_mode == dms_pkg::END_ON) begin
                            n_stop = 1'b1;
                        end else if (nesting) begin
                            n_balance = bal_dec;
                        end
                    end else begin
                        n_seen_other = 1'b1;
                        if ((r_end_mode == dms_pkg::END_AFTER) && sd &&
                            (r_balance == dms_pkg::BAL_ZERO)) begin
                            n_stop = 1'b1;
                        end else if (anti_hit) begin
                            n_balance = bal_inc;
                        end
                    end
                end
            end
            if (n_stop) begin
                n_done = 1'b1;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_chars <= '0;
            r_delim_count <= '0;
            r_anti_chars  <= '0;
            r_anti_count  <= '0;
            r_end_mode    <= dms_pkg::END_ON;
            r_para_breaks <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dms_pkg::REG_DELIM_CHARS: r_delim_chars <= i_cfg_data[dms_pkg::SET_W-1:0];
                dms_pkg::REG_DELIM_COUNT: r_delim_count <= i_cfg_data[dms_pkg::CNT_W-1:0];
                dms_pkg::REG_ANTI_CHARS:  r_anti_chars  <= i_cfg_data[dms_pkg::SET_W-1:0];
                dms_pkg::REG_ANTI_COUNT:  r_anti_count  <= i_cfg_data[dms_pkg::CNT_W-1:0];
                dms_pkg::REG_END_MODE:    r_end_mode    <= i_cfg_data[1:0];
                dms_pkg::REG_PARA_BREAKS: r_para_breaks <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // scan state advances only on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_delim <= 1'b0;
            r_seen_other <= 1'b0;
            r_balance    <= dms_pkg::BAL_ZERO;
            r_done       <= 1'b1;
        end else if (accept) begin
            r_seen_delim <= n_seen_delim;
            r_seen_other <= n_seen_other;
            r_balance    <= n_balance;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_stop <= n_stop;
            r_out_back <= n_back;
        end
    end

    `DMS_ASSERT_NOW(a_back_needs_stop, r_out_valid && r_out_back, r_out_stop,
        "back_one without stop")
    `DMS_ASSERT_NEXT(a_idle_step_quiet, accept && !is_start && r_done,
        r_out_valid && !r_out_stop && !r_out_back, "step after stop reported a result")
    `DMS_ASSERT_NEXT(a_stop_ends_scan, accept && n_stop, r_done,
        "scan still open after a stop")
    `DMS_ASSERT_NEXT(a_start_clears_bal, accept && is_start,
        (r_balance == dms_pkg::BAL_ZERO) && !r_done && !r_seen_delim,
        "start did not reset the scan state")
    `DMS_ASSERT_NEXT(a_bal_frozen_idle, r_done && !(accept && is_start), $stable(r_balance),
        "balance moved while no scan was open")

endmodule
